// ===== rtl/snu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snu_pkg: shared types and constants of the surface normal unit
// Field widths, fixed-point formats, CORDIC tables and pipeline splits.
// ----------------------------------------------------------------------------
package snu_pkg;

    // Port field widths
    localparam int FUNC_W        = 2;
    localparam int COORD_W       = 32;
    localparam int ANGLE_W       = 17;
    localparam int NORM_W        = 18;
    localparam int DEF_FRAC_BITS = 16;

    // Stream word widths (fields packed from bit 0, padded to bytes)
    localparam int IN_FIELDS_W = 10 * COORD_W + ANGLE_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((3 * NORM_W + 7) / 8) * 8;

    // Shape select
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SPHERE   = 2'd0,
        FUNC_PLANE    = 2'd1,
        FUNC_CYLINDER = 2'd2,
        FUNC_CONE     = 2'd3
    } t_func;

    // Raw vector formats
    localparam int DIFF_W = COORD_W + 1;        // hit - center, exact
    localparam int UNIT_W = 17;                 // cos/sin in Q16, 0..65536
    localparam int MAG_W  = 49;                 // |d| * cos fits below 2^49

    // CORDIC, Q24 internal
    localparam int CORDIC_STEPS     = 24;
    localparam int CORDIC_PER_STAGE = 3;
    localparam int CORDIC_W         = 27;
    localparam int Q_SHIFT          = 8;        // Q16 <-> Q24
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 27'sd10188014;
    localparam logic signed [CORDIC_W-1:0] CORDIC_ROUND = 27'sd128;
    localparam logic [ANGLE_W-1:0]         HALF_PI_Q16  = 17'd102944;
    localparam logic [UNIT_W-1:0]          UNIT_ONE     = 17'd65536;

    // Normalization
    localparam int CHUNK_W  = 7;
    localparam int NCHUNK   = (MAG_W + CHUNK_W - 1) / CHUNK_W;
    localparam int CPOS_W   = $clog2(CHUNK_W);
    localparam int POS_W    = $clog2(MAG_W);
    localparam int NORM_MSB = 29;               // scaled max lies in [2^29, 2^30)
    localparam int SCL_W    = NORM_MSB + 1;
    localparam int SQ_W     = 2 * SCL_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int ISQ_PER_STAGE = 2;
    localparam int NORM_FRAC = 16;
    localparam int NUM_W    = SCL_W + NORM_FRAC + 1;
    localparam int QUO_W    = NORM_FRAC + 1;
    localparam int DIV_PER_STAGE = 2;

    // Front-end word carried beside the CORDIC
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] mag;
        logic [2:0]             neg;
        logic                   cone;
    } t_front;

    // Scaled word carried beside the square root
    typedef struct packed {
        logic [2:0][SCL_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } t_scaled;

    // Arctangent of 2^-i in Q24
    function automatic logic signed [CORDIC_W-1:0] cordic_atan(input int idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            0:       v = 27'sd13176795;
            1:       v = 27'sd7778716;
            2:       v = 27'sd4110060;
            3:       v = 27'sd2086331;
            4:       v = 27'sd1047214;
            5:       v = 27'sd524117;
            6:       v = 27'sd262123;
            7:       v = 27'sd131069;
            8:       v = 27'sd65536;
            9:       v = 27'sd32768;
            10:      v = 27'sd16384;
            11:      v = 27'sd8192;
            12:      v = 27'sd4096;
            13:      v = 27'sd2048;
            14:      v = 27'sd1024;
            15:      v = 27'sd512;
            16:      v = 27'sd256;
            17:      v = 27'sd128;
            18:      v = 27'sd64;
            19:      v = 27'sd32;
            20:      v = 27'sd16;
            21:      v = 27'sd8;
            22:      v = 27'sd4;
            23:      v = 27'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/snu_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snu_cordic: pipelined sine/cosine of the cone half-angle
// Rotation-mode CORDIC in Q24, a few micro-rotations per stage, with a side
// word that travels along unchanged.
// ----------------------------------------------------------------------------
module snu_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [snu_pkg::ANGLE_W-1:0]           i_angle,
    input  logic [SIDE_W-1:0]                     i_side,
    output logic                                  o_vld,
    output logic signed [snu_pkg::CORDIC_W-1:0]   o_cos,
    output logic signed [snu_pkg::CORDIC_W-1:0]   o_sin,
    output logic [SIDE_W-1:0]                     o_side
);
    import snu_pkg::*;

    localparam int NST = (CORDIC_STEPS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;

    logic signed [CORDIC_W-1:0] r_x [NST+1];
    logic signed [CORDIC_W-1:0] r_y [NST+1];
    logic signed [CORDIC_W-1:0] r_z [NST+1];
    logic [SIDE_W-1:0]          r_side [NST+1];
    logic [NST:0]               r_vld;
    logic [ANGLE_W-1:0]         n_angle;

    // Saturate the angle at pi/2
    always_comb begin
        n_angle = (i_angle > HALF_PI_Q16) ? HALF_PI_Q16 : i_angle;
    end

    // Load the start vector
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= CORDIC_W'({n_angle, {Q_SHIFT{1'b0}}});
            r_side[0] <= i_side;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-1:0], i_vld};
        end
    end

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic signed [CORDIC_W-1:0] n_x, n_y, n_z;

        // Micro-rotations of this stage
        always_comb begin
            logic signed [CORDIC_W-1:0] dx, dy;
            n_x = r_x[s];
            n_y = r_y[s];
            n_z = r_z[s];
            dx  = '0;
            dy  = '0;
            for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
                if (s * CORDIC_PER_STAGE + k < CORDIC_STEPS) begin
                    dx = n_y >>> (s * CORDIC_PER_STAGE + k);
                    dy = n_x >>> (s * CORDIC_PER_STAGE + k);
                    if (!n_z[CORDIC_W-1]) begin
                        n_x = n_x - dx;
                        n_y = n_y + dy;
                        n_z = n_z - cordic_atan(s * CORDIC_PER_STAGE + k);
                    end else begin
                        n_x = n_x + dx;
                        n_y = n_y - dy;
                        n_z = n_z + cordic_atan(s * CORDIC_PER_STAGE + k);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s+1]    <= n_x;
                r_y[s+1]    <= n_y;
                r_z[s+1]    <= n_z;
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_vld  = r_vld[NST];
    assign o_cos  = r_x[NST];
    assign o_sin  = r_y[NST];
    assign o_side = r_side[NST];

endmodule

// ===== rtl/snu_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snu_isqrt: pipelined integer square root
// Digit-by-digit floor square root, two result bits per stage, with a side
// word that travels along unchanged.
// ----------------------------------------------------------------------------
module snu_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [snu_pkg::SUM_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_vld,
    output logic [snu_pkg::ROOT_W-1:0]    o_root,
    output logic [SIDE_W-1:0]             o_side
);
    import snu_pkg::*;

    localparam int NST = (ROOT_W + ISQ_PER_STAGE - 1) / ISQ_PER_STAGE;

    logic [SUM_W-1:0]  r_rad  [NST+1];
    logic [REM_W-1:0]  r_rem  [NST+1];
    logic [ROOT_W-1:0] r_root [NST+1];
    logic [SIDE_W-1:0] r_side [NST+1];
    logic [NST:0]      r_vld;

    // Load the radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-1:0], i_vld};
        end
    end

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic [SUM_W-1:0]  n_rad;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        // Bring down two radicand bits per step, try a one digit
        always_comb begin
            logic [REM_W+1:0] cat, sub;
            n_rad  = r_rad[s];
            n_rem  = r_rem[s];
            n_root = r_root[s];
            cat    = '0;
            sub    = '0;
            for (int k = 0; k < ISQ_PER_STAGE; k++) begin
                if (s * ISQ_PER_STAGE + k < ROOT_W) begin
                    cat   = {n_rem, n_rad[SUM_W-1 -: 2]};
                    sub   = (REM_W + 2)'({n_root, 2'b01});
                    n_rad = n_rad << 2;
                    if (cat >= sub) begin
                        n_rem  = REM_W'(cat - sub);
                        n_root = {n_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        n_rem  = REM_W'(cat);
                        n_root = {n_root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s+1]  <= n_rad;
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= n_root;
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_vld  = r_vld[NST];
    assign o_root = r_root[NST];
    assign o_side = r_side[NST];

endmodule

// ===== rtl/surface_normal_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_normal_unit: unit surface normal of a ray-tracer hit point
// The unit takes one input word per clock while the pipe is not held and
// returns one normal word for each, in order. The depth of the pipe is set by the
// pipelined 24-step CORDIC (8 stages), the 31-bit square root (16 stages)
// and the 17-bit divide (9 stages). All stages share one enable: when the
// result word is not taken, the whole pipe holds and s_axis_tready drops.
// Shape 0 normalizes the hit point, 1 the plane direction, 2 the radial XZ
// offset signed by the radius, 3 the cone normal from the half-angle. A
// zero-length vector gives an all-zero normal with tuser set.
// ----------------------------------------------------------------------------
module surface_normal_unit #(
    parameter int FRAC_BITS = snu_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // hit_x, hit_y, hit_z, center_x, center_y, center_z, dir_x, dir_y,
    // dir_z, radius (32 bits each), half_angle (17 bits), zero pad
    input  logic [snu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func
    input  logic [snu_pkg::FUNC_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // norm_x, norm_y, norm_z (18 bits each), zero pad
    output logic [snu_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // degenerate
    output logic [0:0]                        m_axis_tuser
);
    import snu_pkg::*;

    localparam int DIV_NST = (QUO_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int PAD_W   = NCHUNK * CHUNK_W;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    function automatic logic [UNIT_W-1:0] to_unit(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] t;
        t = (v + CORDIC_ROUND) >>> Q_SHIFT;
        if (t[CORDIC_W-1]) begin
            return '0;
        end else if (t > CORDIC_W'(UNIT_ONE)) begin
            return UNIT_ONE;
        end
        return UNIT_W'(t);
    endfunction

    logic en;

    // ---------------- stage 1: raw vector per shape ----------------
    logic signed [COORD_W-1:0] w_hit [3];
    logic signed [COORD_W-1:0] w_ctr [3];
    logic signed [COORD_W-1:0] w_dir [3];
    logic signed [COORD_W-1:0] w_radius;
    logic [ANGLE_W-1:0]        w_angle;
    t_front                    n1_front;
    t_front                    r1_front;
    logic [ANGLE_W-1:0]        r1_angle;
    logic                      r1_vld;

    // Unpack the input word
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_hit[i] = s_axis_tdata[i * COORD_W +: COORD_W];
            w_ctr[i] = s_axis_tdata[(i + 3) * COORD_W +: COORD_W];
            w_dir[i] = s_axis_tdata[(i + 6) * COORD_W +: COORD_W];
        end
        w_radius = s_axis_tdata[9 * COORD_W +: COORD_W];
        w_angle  = s_axis_tdata[10 * COORD_W +: ANGLE_W];
    end

    // Form magnitudes and signs of the raw vector
    always_comb begin
        logic signed [DIFF_W-1:0] d [3];
        for (int i = 0; i < 3; i++) begin
            d[i] = DIFF_W'(w_hit[i]) - DIFF_W'(w_ctr[i]);
        end
        n1_front = '0;
        case (t_func'(s_axis_tuser))
            FUNC_SPHERE: begin
                for (int i = 0; i < 3; i++) begin
                    n1_front.mag[i] = abs_diff(DIFF_W'(w_hit[i]));
                    n1_front.neg[i] = w_hit[i][COORD_W-1];
                end
            end
            FUNC_PLANE: begin
                for (int i = 0; i < 3; i++) begin
                    n1_front.mag[i] = abs_diff(DIFF_W'(w_dir[i]));
                    n1_front.neg[i] = w_dir[i][COORD_W-1];
                end
            end
            FUNC_CYLINDER: begin
                if (w_radius != '0) begin
                    n1_front.mag[0] = abs_diff(d[0]);
                    n1_front.mag[2] = abs_diff(d[2]);
                end
                n1_front.neg[0] = d[0][DIFF_W-1] ^ w_radius[COORD_W-1];
                n1_front.neg[2] = d[2][DIFF_W-1] ^ w_radius[COORD_W-1];
            end
            FUNC_CONE: begin
                n1_front.mag[0] = abs_diff(d[0]);
                n1_front.mag[2] = abs_diff(d[2]);
                n1_front.neg[0] = d[0][DIFF_W-1];
                n1_front.neg[2] = d[2][DIFF_W-1];
                n1_front.neg[1] = !d[1][DIFF_W-1];
                n1_front.cone   = 1'b1;
            end
            default: begin
                n1_front = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_front <= n1_front;
            r1_angle <= w_angle;
        end
    end

    // ---------------- CORDIC ----------------
    logic                       c_vld;
    logic signed [CORDIC_W-1:0] c_cos, c_sin;
    logic [$bits(t_front)-1:0]  c_side;

    snu_cordic #(
        .SIDE_W ($bits(t_front))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r1_vld),
        .i_angle (r1_angle),
        .i_side  (r1_front),
        .o_vld   (c_vld),
        .o_cos   (c_cos),
        .o_sin   (c_sin),
        .o_side  (c_side)
    );

    // ---------------- stage 2: round sine and cosine ----------------
    t_front            r2_front;
    logic [UNIT_W-1:0] r2_cos, r2_sin;
    logic              r2_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_front <= t_front'(c_side);
            r2_cos   <= to_unit(c_cos);
            r2_sin   <= to_unit(c_sin);
        end
    end

    // ---------------- stage 3: cone scaling ----------------
    logic [MAG_W-1:0] n3_mag [3];
    logic [MAG_W-1:0] r3_mag [3];
    logic [2:0]       r3_neg;
    logic             r3_vld;

    always_comb begin
        logic [DIFF_W+UNIT_W-1:0] prod;
        prod = '0;
        for (int i = 0; i < 3; i++) begin
            prod      = r2_front.mag[i] * r2_cos;
            n3_mag[i] = r2_front.cone ? MAG_W'(prod) : MAG_W'(r2_front.mag[i]);
        end
        if (r2_front.cone) begin
            n3_mag[1] = MAG_W'(r2_sin) << FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mag <= n3_mag;
            r3_neg <= r2_front.neg;
        end
    end

    // ---------------- stage 4: largest magnitude ----------------
    logic [MAG_W-1:0] n4_max;
    logic [MAG_W-1:0] r4_mag [3];
    logic [MAG_W-1:0] r4_max;
    logic [2:0]       r4_neg;
    logic             r4_vld;

    always_comb begin
        n4_max = r3_mag[0];
        if (r3_mag[1] > n4_max) begin
            n4_max = r3_mag[1];
        end
        if (r3_mag[2] > n4_max) begin
            n4_max = r3_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_mag <= r3_mag;
            r4_max <= n4_max;
            r4_neg <= r3_neg;
        end
    end

    // ---------------- stage 5: leading one within each chunk ----------------
    logic [NCHUNK-1:0] n5_nz;
    logic [CPOS_W-1:0] n5_pos [NCHUNK];
    logic [MAG_W-1:0]  r5_mag [3];
    logic [NCHUNK-1:0] r5_nz;
    logic [CPOS_W-1:0] r5_pos [NCHUNK];
    logic              r5_zero;
    logic [2:0]        r5_neg;
    logic              r5_vld;

    always_comb begin
        logic [PAD_W-1:0] pad;
        pad = PAD_W'(r4_max);
        for (int c = 0; c < NCHUNK; c++) begin
            n5_nz[c]  = |pad[c * CHUNK_W +: CHUNK_W];
            n5_pos[c] = '0;
            for (int k = 0; k < CHUNK_W; k++) begin
                if (pad[c * CHUNK_W + k]) begin
                    n5_pos[c] = CPOS_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mag  <= r4_mag;
            r5_nz   <= n5_nz;
            r5_pos  <= n5_pos;
            r5_zero <= (r4_max == '0);
            r5_neg  <= r4_neg;
        end
    end

    // ---------------- stage 6: shift amount ----------------
    logic [POS_W-1:0] n6_msb;
    logic [MAG_W-1:0] r6_mag [3];
    logic             r6_left;
    logic [POS_W-1:0] r6_amt;
    logic             r6_zero;
    logic [2:0]       r6_neg;
    logic             r6_vld;

    always_comb begin
        n6_msb = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            if (r5_nz[c]) begin
                n6_msb = POS_W'(c * CHUNK_W) + POS_W'(r5_pos[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_mag  <= r5_mag;
            r6_left <= (n6_msb < POS_W'(NORM_MSB));
            r6_amt  <= (n6_msb < POS_W'(NORM_MSB)) ? POS_W'(NORM_MSB) - n6_msb
                                                   : n6_msb - POS_W'(NORM_MSB);
            r6_zero <= r5_zero;
            r6_neg  <= r5_neg;
        end
    end

    // ---------------- stage 7: common power-of-two scaling ----------------
    logic [SCL_W-1:0] n7_mag [3];
    logic [SCL_W-1:0] r7_mag [3];
    logic             r7_zero;
    logic [2:0]       r7_neg;
    logic             r7_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_mag[i] = r6_left ? SCL_W'(r6_mag[i] << r6_amt) : SCL_W'(r6_mag[i] >> r6_amt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_mag  <= n7_mag;
            r7_zero <= r6_zero;
            r7_neg  <= r6_neg;
        end
    end

    // ---------------- stage 8: squares ----------------
    logic [SQ_W-1:0] r8_sq [3];
    t_scaled         r8_side;
    logic            r8_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_sq[i]       <= r7_mag[i] * r7_mag[i];
                r8_side.mag[i] <= r7_mag[i];
            end
            r8_side.neg   <= r7_neg;
            r8_side.degen <= r7_zero;
        end
    end

    // ---------------- stage 9: sum of squares ----------------
    logic [SUM_W-1:0] r9_sum;
    t_scaled          r9_side;
    logic             r9_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_sum  <= SUM_W'(r8_sq[0]) + SUM_W'(r8_sq[1]) + SUM_W'(r8_sq[2]);
            r9_side <= r8_side;
        end
    end

    // ---------------- square root ----------------
    logic                       q_vld;
    logic [ROOT_W-1:0]          q_root;
    logic [$bits(t_scaled)-1:0] q_side_bits;
    t_scaled                    q_side;

    snu_isqrt #(
        .SIDE_W ($bits(t_scaled))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r9_vld),
        .i_rad   (r9_sum),
        .i_side  (r9_side),
        .o_vld   (q_vld),
        .o_root  (q_root),
        .o_side  (q_side_bits)
    );

    assign q_side = t_scaled'(q_side_bits);

    // ---------------- divide: mag * 2^16 / root, rounded ----------------
    logic [NUM_W-1:0]  r_drem [3][DIV_NST+1];
    logic [QUO_W-1:0]  r_dquo [3][DIV_NST+1];
    logic [ROOT_W-1:0] r_dden [DIV_NST+1];
    logic [2:0]        r_dneg [DIV_NST+1];
    logic              r_ddeg [DIV_NST+1];
    logic [DIV_NST:0]  r_dvld;

    // Load numerators with the half-divisor rounding term
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_drem[l][0] <= NUM_W'({q_side.mag[l], {NORM_FRAC{1'b0}}})
                              + NUM_W'(q_root >> 1);
                r_dquo[l][0] <= '0;
            end
            r_dden[0] <= q_root;
            r_dneg[0] <= q_side.neg;
            r_ddeg[0] <= q_side.degen;
        end
    end

    for (genvar s = 0; s < DIV_NST; s++) begin : g_div
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [NUM_W-1:0] n_rem;
            logic [QUO_W-1:0] n_quo;

            // Restoring divide, most significant quotient bits first
            always_comb begin
                logic [NUM_W:0] dsh;
                n_rem = r_drem[l][s];
                n_quo = r_dquo[l][s];
                dsh   = '0;
                for (int k = 0; k < DIV_PER_STAGE; k++) begin
                    if (s * DIV_PER_STAGE + k < QUO_W) begin
                        dsh = (NUM_W + 1)'(r_dden[s]) << (QUO_W - 1 - (s * DIV_PER_STAGE + k));
                        if ((NUM_W + 1)'(n_rem) >= dsh) begin
                            n_rem = n_rem - NUM_W'(dsh);
                            n_quo[QUO_W - 1 - (s * DIV_PER_STAGE + k)] = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_drem[l][s+1] <= n_rem;
                    r_dquo[l][s+1] <= n_quo;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dden[s+1] <= r_dden[s];
                r_dneg[s+1] <= r_dneg[s];
                r_ddeg[s+1] <= r_ddeg[s];
            end
        end
    end

    // ---------------- output register ----------------
    logic signed [NORM_W-1:0] n_norm [3];
    logic signed [NORM_W-1:0] r_norm [3];
    logic                     r_degen;
    logic                     r_out_vld;

    // Clamp, restore sign, zero a degenerate normal
    always_comb begin
        logic [UNIT_W-1:0] q;
        q = '0;
        for (int i = 0; i < 3; i++) begin
            q = (r_dquo[i][DIV_NST] > UNIT_ONE) ? UNIT_ONE : r_dquo[i][DIV_NST];
            if (r_ddeg[DIV_NST]) begin
                n_norm[i] = '0;
            end else if (r_dneg[DIV_NST][i]) begin
                n_norm[i] = -NORM_W'(q);
            end else begin
                n_norm[i] = NORM_W'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_norm  <= n_norm;
            r_degen <= r_ddeg[DIV_NST];
        end
    end

    // Advance valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r8_vld    <= 1'b0;
            r9_vld    <= 1'b0;
            r_dvld    <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= s_axis_tvalid;
            r2_vld    <= c_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r8_vld    <= r7_vld;
            r9_vld    <= r8_vld;
            r_dvld    <= {r_dvld[DIV_NST-1:0], q_vld};
            r_out_vld <= r_dvld[DIV_NST];
        end
    end

    // Hold the whole pipe while a result word waits
    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'({r_norm[2], r_norm[1], r_norm[0]});
    assign m_axis_tuser  = r_degen;

    // ---------------- assertions ----------------
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate word carries a nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ($signed(r_norm[0]) <= 18'sd65536) && ($signed(r_norm[0]) >= -18'sd65536) &&
            ($signed(r_norm[1]) <= 18'sd65536) && ($signed(r_norm[1]) >= -18'sd65536) &&
            ($signed(r_norm[2]) <= 18'sd65536) && ($signed(r_norm[2]) >= -18'sd65536))
        else $error("normal component outside unit range");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r9_vld && !s_axis_tready |=> r9_vld)
        else $error("item dropped from the pipe during a stall");

endmodule
